FILE: rtl/core/usrb_pkg.sv
// Shared types, register codes, bit positions and helper functions of the serial register block.
package usrb_pkg;

  localparam int USRB_QUEUE_DEPTH = 2;
  localparam int IN_DATA_W        = 16;
  localparam int IN_USER_W        = 3;
  localparam int OUT_DATA_W       = 32;

  typedef enum logic [2:0] {
    REQ_READ     = 3'd0,
    REQ_WRITE    = 3'd1,
    REQ_RX_CHAR  = 3'd2,
    REQ_RX_BREAK = 3'd3,
    REQ_TICK     = 3'd4,
    REQ_SPI      = 3'd5,
    REQ_NONE     = 3'd6
  } req_kind_t;

  typedef enum logic [2:0] {
    ADDR_CTL0  = 3'd0,
    ADDR_CTL1  = 3'd1,
    ADDR_BR0   = 3'd2,
    ADDR_BR1   = 3'd3,
    ADDR_MCTL  = 3'd4,
    ADDR_STAT  = 3'd5,
    ADDR_RXBUF = 3'd6,
    ADDR_TXBUF = 3'd7
  } reg_addr_t;

  // spi modes in ctl0[2:1]
  typedef enum logic [1:0] {
    SPI_MODE_3PIN   = 2'd0,
    SPI_MODE_STE_HI = 2'd1,
    SPI_MODE_STE_LO = 2'd2,
    SPI_MODE_I2C    = 2'd3
  } spi_mode_t;

  // control0 bits
  localparam int CTL0_SYNC  = 0;
  localparam int CTL0_7BIT  = 4;
  localparam int CTL0_MSB   = 5;
  // control1 bits
  localparam int CTL1_SWRST = 0;
  localparam int CTL1_TXBRK = 1;
  localparam int CTL1_DORM  = 3;
  localparam int CTL1_BRKIE = 4;
  localparam int CTL1_RXEIE = 5;
  // status bits
  localparam int STAT_BUSY   = 0;
  localparam int STAT_RXERR  = 2;
  localparam int STAT_BRK    = 3;
  localparam int STAT_OE     = 5;
  localparam int STAT_LISTEN = 7;
  localparam logic [7:0] STAT_RX_BITS = 8'h76;

  typedef struct packed {
    req_kind_t  kind;
    reg_addr_t  addr;
    logic [7:0] data;
    logic       ste;
  } usrb_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } usrb_q_status_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  function automatic logic [7:0] load_conv(input logic [7:0] ctl0, input logic [7:0] d);
    logic [7:0] r;
    r = d;
    if (ctl0[CTL0_MSB]) begin
      r = rev8(d);
      if (ctl0[CTL0_7BIT]) begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] tx_conv(input logic [7:0] ctl0, input logic [7:0] t);
    logic [7:0] r;
    r = t;
    if (ctl0[CTL0_7BIT]) begin
      r = r & 8'h7f;
    end
    if (ctl0[CTL0_MSB]) begin
      r = rev8(r);
      if (ctl0[CTL0_7BIT]) begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/usrb_front.sv
// Input side: takes items off the slave stream and classifies them for the queue.
module usrb_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [usrb_pkg::IN_DATA_W-1:0]         s_tdata,  // reg_addr[2:0], data_in[10:3], ste_level[11]
  input  logic [usrb_pkg::IN_USER_W-1:0]         s_tuser,  // req_type[2:0]
  input  usrb_pkg::usrb_q_status_t               q_stat,
  output logic                                   push,
  output usrb_pkg::usrb_item_t                   item
);
  import usrb_pkg::*;

  req_kind_t kind;
  logic      seen_reset;

  // holds ready low from reset until seen_reset is set by a clock edge with rst low
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_reset <= 1'b0;
    end else begin
      seen_reset <= 1'b1;
    end
  end

  always_comb begin
    if (s_tuser > IN_USER_W'(REQ_SPI)) begin
      kind = REQ_NONE;
    end else begin
      kind = req_kind_t'(s_tuser);
    end
  end

  assign s_tready   = seen_reset && !q_stat.full;
  assign push       = s_tvalid && s_tready;
  assign item.kind  = kind;
  assign item.addr  = reg_addr_t'(s_tdata[2:0]);
  assign item.data  = s_tdata[10:3];
  assign item.ste   = s_tdata[11];

endmodule

FILE: rtl/core/usrb_queue.sv
// Short queue of classified items between the front and the back.
module usrb_queue #(
  parameter int DEPTH = usrb_pkg::USRB_QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  usrb_pkg::usrb_item_t     push_item,
  input  logic                     pop,
  output usrb_pkg::usrb_item_t     head,
  output usrb_pkg::usrb_q_status_t q_stat
);
  import usrb_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  usrb_item_t    mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head         = mem[rd_ptr];
  assign q_stat.empty = (count == '0);
  assign q_stat.full  = (count == FULL_CNT);

endmodule

FILE: rtl/core/usrb_back.sv
// Execution side: register file, flag logic and the registered result stream.
module usrb_back (
  input  logic                                clk,
  input  logic                                rst,
  input  usrb_pkg::usrb_item_t                head,
  input  usrb_pkg::usrb_q_status_t            q_stat,
  output logic                                pop,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [usrb_pkg::OUT_DATA_W-1:0]     m_tdata
);
  import usrb_pkg::*;

  logic [7:0]  control0, control0_next;
  logic [7:0]  control1, control1_next;
  logic [15:0] baud_divider, baud_divider_next;
  logic [7:0]  modulation, modulation_next;
  logic [7:0]  status_bits, status_bits_next;
  logic [7:0]  receive_byte, receive_byte_next;
  logic [7:0]  transmit_byte, transmit_byte_next;
  logic        sending, sending_next;
  logic        send_ready, send_ready_next;
  logic        unread_flag, unread_flag_next;
  logic        rx_irq_level, rx_irq_level_next;
  logic        tx_irq_level, tx_irq_level_next;

  logic [7:0]  rd_data, tx_char, spi_out, rx_char;
  logic        tx_valid, tx_break, clear_fifos, timer_start, timer_stop;
  logic        do_send, do_rx, spi_take;
  spi_mode_t   spi_mode;

  assign pop = !q_stat.empty && (!m_tvalid || m_tready);
  assign spi_mode = spi_mode_t'(control0[2:1]);

  always_comb begin
    control0_next      = control0;
    control1_next      = control1;
    baud_divider_next  = baud_divider;
    modulation_next    = modulation;
    status_bits_next   = status_bits;
    receive_byte_next  = receive_byte;
    transmit_byte_next = transmit_byte;
    sending_next       = sending;
    send_ready_next    = send_ready;
    unread_flag_next   = unread_flag;
    rx_irq_level_next  = rx_irq_level;
    tx_irq_level_next  = tx_irq_level;
    rd_data     = '0;
    tx_valid    = 1'b0;
    tx_char     = '0;
    tx_break    = 1'b0;
    spi_out     = '0;
    clear_fifos = 1'b0;
    timer_start = 1'b0;
    timer_stop  = 1'b0;
    do_send     = 1'b0;
    do_rx       = 1'b0;
    rx_char     = '0;
    spi_take    = 1'b0;

    case (head.kind)
      REQ_READ: begin
        unique case (head.addr)
          ADDR_CTL0: rd_data = control0;
          ADDR_CTL1: rd_data = control1;
          ADDR_BR0:  rd_data = baud_divider[7:0];
          ADDR_BR1:  rd_data = baud_divider[15:8];
          ADDR_MCTL: rd_data = modulation;
          ADDR_STAT: begin
            status_bits_next[STAT_BUSY] = sending;
            rd_data = {status_bits[7:1], sending};
          end
          ADDR_RXBUF: begin
            rx_irq_level_next = 1'b0;
            status_bits_next  = status_bits & ~STAT_RX_BITS;
            unread_flag_next  = 1'b0;
            rd_data = receive_byte;
          end
          ADDR_TXBUF: rd_data = transmit_byte;
          default: rd_data = '0;
        endcase
      end
      REQ_WRITE: begin
        unique case (head.addr)
          ADDR_CTL0: begin
            control0_next = head.data;
            timer_stop = !control1[CTL1_SWRST];
          end
          ADDR_CTL1: begin
            control1_next = head.data;
            if (head.data[CTL1_SWRST] != control1[CTL1_SWRST]) begin
              timer_stop = 1'b1;
              if (head.data[CTL1_SWRST]) begin
                clear_fifos       = 1'b1;
                rx_irq_level_next = 1'b0;
                tx_irq_level_next = 1'b1;
                sending_next      = 1'b0;
                send_ready_next   = 1'b1;
                unread_flag_next  = 1'b0;
                status_bits_next  = status_bits & ~STAT_RX_BITS;
              end
            end
          end
          ADDR_BR0: begin
            baud_divider_next[7:0] = head.data;
            timer_stop = !control1[CTL1_SWRST];
          end
          ADDR_BR1: begin
            baud_divider_next[15:8] = head.data;
            timer_stop = !control1[CTL1_SWRST];
          end
          ADDR_MCTL: begin
            modulation_next = head.data;
            timer_stop = !control1[CTL1_SWRST] && !control0[CTL0_SYNC];
          end
          ADDR_STAT: status_bits_next = head.data;
          ADDR_RXBUF: ;
          ADDR_TXBUF: begin
            transmit_byte_next = head.data;
            do_send = 1'b1;
          end
          default: ;
        endcase
      end
      REQ_RX_CHAR: begin
        if (!control1[CTL1_SWRST] && !status_bits[STAT_LISTEN]) begin
          do_rx   = 1'b1;
          rx_char = head.data;
        end
      end
      REQ_RX_BREAK: begin
        status_bits_next[STAT_BRK] = 1'b1;
        if (control1[CTL1_BRKIE]) begin
          rx_irq_level_next = 1'b1;
        end
        do_rx   = 1'b1;
        rx_char = '0;
      end
      REQ_TICK: begin
        if (send_ready) begin
          sending_next = 1'b0;
        end else begin
          do_send = 1'b1;
        end
      end
      REQ_SPI: begin
        spi_take = !control1[CTL1_SWRST] && !status_bits[STAT_LISTEN] &&
                   control0[CTL0_SYNC] && (spi_mode != SPI_MODE_I2C) &&
                   !((spi_mode == SPI_MODE_STE_HI) && !head.ste) &&
                   !((spi_mode == SPI_MODE_STE_LO) && head.ste);
        if (spi_take) begin
          if (unread_flag) begin
            status_bits_next[STAT_OE] = 1'b1;
          end else begin
            receive_byte_next = load_conv(control0, head.data);
            unread_flag_next  = 1'b1;
            rx_irq_level_next = 1'b1;
          end
          tx_irq_level_next = 1'b1;
          send_ready_next   = 1'b1;
          spi_out = tx_conv(control0, transmit_byte);
        end
      end
      default: ;
    endcase

    // transmit, then loop back in listen mode
    if (do_send) begin
      tx_valid = 1'b1;
      if (control1_next[CTL1_TXBRK]) begin
        tx_break = 1'b1;
        control1_next[CTL1_TXBRK] = 1'b0;
      end else begin
        tx_char = tx_conv(control0_next, transmit_byte_next);
      end
      if (status_bits_next[STAT_LISTEN]) begin
        do_rx   = 1'b1;
        rx_char = transmit_byte_next;
      end
      timer_start = 1'b1;
      if (!send_ready_next) begin
        tx_irq_level_next = 1'b1;
      end
      sending_next    = 1'b1;
      send_ready_next = 1'b1;
    end

    if (do_rx) begin
      if (unread_flag_next) begin
        status_bits_next[STAT_OE]    = 1'b1;
        status_bits_next[STAT_RXERR] = 1'b1;
        if (control1_next[CTL1_RXEIE]) begin
          rx_irq_level_next = 1'b1;
        end
      end else begin
        receive_byte_next = load_conv(control0_next, rx_char);
        unread_flag_next  = 1'b1;
        if (!control1_next[CTL1_DORM]) begin
          rx_irq_level_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control0      <= '0;
      control1      <= 8'h01;
      baud_divider  <= '0;
      modulation    <= '0;
      status_bits   <= '0;
      receive_byte  <= '0;
      transmit_byte <= '0;
      sending       <= 1'b0;
      send_ready    <= 1'b1;
      unread_flag   <= 1'b0;
      rx_irq_level  <= 1'b0;
      tx_irq_level  <= 1'b1;
      m_tvalid      <= 1'b0;
    end else if (pop) begin
      control0      <= control0_next;
      control1      <= control1_next;
      baud_divider  <= baud_divider_next;
      modulation    <= modulation_next;
      status_bits   <= status_bits_next;
      receive_byte  <= receive_byte_next;
      transmit_byte <= transmit_byte_next;
      sending       <= sending_next;
      send_ready    <= send_ready_next;
      unread_flag   <= unread_flag_next;
      rx_irq_level  <= rx_irq_level_next;
      tx_irq_level  <= tx_irq_level_next;
      m_tvalid      <= 1'b1;
    end else if (m_tready) begin
      m_tvalid      <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= {1'b0, timer_stop, timer_start, clear_fifos, tx_irq_level_next,
                  rx_irq_level_next, spi_out, tx_break, tx_char, tx_valid, rd_data};
    end
  end

endmodule

FILE: rtl/core/uart_spi_serial_register_block_top.sv
// Top level of the serial register block: front, item queue and back.
// A result passes through the item queue and the output register to the master side.
// Throughput: one item per cycle; the back retires one queued item each cycle the
// output register is free or being taken, the queue holds QUEUE_DEPTH items.
// Reset: rst is synchronous, active high; it empties the queue, drops m_tvalid and
// loads the register reset values (control1 software reset set, tx irq high).
module uart_spi_serial_register_block_top #(
  parameter int QUEUE_DEPTH = usrb_pkg::USRB_QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [usrb_pkg::IN_DATA_W-1:0]    s_tdata,  // reg_addr[2:0], data_in[10:3], ste_level[11]
  input  logic [usrb_pkg::IN_USER_W-1:0]    s_tuser,  // req_type[2:0]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [usrb_pkg::OUT_DATA_W-1:0]   m_tdata   // rd_data[7:0], tx_valid[8], tx_char[16:9],
                                                      // tx_break[17], spi_out[25:18], rx_irq[26],
                                                      // tx_irq[27], clear_fifos[28],
                                                      // timer_start[29], timer_stop[30]
);
  import usrb_pkg::*;

  usrb_item_t     push_item;
  usrb_item_t     head;
  usrb_q_status_t q_stat;
  logic           push;
  logic           pop;

  usrb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_stat   (q_stat),
    .push     (push),
    .item     (push_item)
  );

  usrb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  usrb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

`ifndef ASSERT_OFF
  // a software reset entry leaves tx irq high and rx irq low
  a_swrst_irq: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[28] |-> m_tdata[27] && !m_tdata[26])
    else $error("clear_fifos without irq reset levels");

  // every transmission starts the character timer; a break carries no character
  a_tx_timer: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[8] |-> m_tdata[29] && !(m_tdata[17] && (m_tdata[16:9] != 8'h00)))
    else $error("transmit without timer start or break with data");

  // the back never retires from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // a retired item shows up on the output in the next cycle
  a_pop_result: assert property (@(posedge clk) disable iff (rst)
    pop |=> m_tvalid)
    else $error("retired item produced no result");
`endif

endmodule

FILE: sim/tb.sv
// Testbench for the serial register block: directed and random bus, line and spi traffic.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import usrb_pkg::*;

  // request code with no enum member, ignored by the block
  localparam logic [2:0] REQ_SPARE = 3'd7;

  // m_tdata layout, lowest field last
  typedef struct packed {
    logic       spare;
    logic       timer_stop;
    logic       timer_start;
    logic       clear_fifos;
    logic       tx_irq;
    logic       rx_irq;
    logic [7:0] spi_out;
    logic       tx_break;
    logic [7:0] tx_char;
    logic       tx_valid;
    logic [7:0] rd_data;
  } line_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  logic        idle_on = 1'b1;
  int          sink_gap = 0;
  int          mismatch_cnt = 0;
  int          checked_cnt = 0;
  int          item_cnt = 0;
  int          kind_cnt[8];

  line_result_t pending_results[$];

  // register file as the block should hold it
  logic [7:0]  ctl0_m = 8'h00;
  logic [7:0]  ctl1_m = 8'h01;
  logic [15:0] baud_m = 16'h0000;
  logic [7:0]  mctl_m = 8'h00;
  logic [7:0]  stat_m = 8'h00;
  logic [7:0]  rxbuf_m = 8'h00;
  logic [7:0]  txbuf_m = 8'h00;
  logic        busy_m = 1'b0;
  logic        txrdy_m = 1'b1;
  logic        unread_m = 1'b0;
  logic        rx_irq_m = 1'b0;
  logic        tx_irq_m = 1'b1;

  uart_spi_serial_register_block_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),  // reg_addr[2:0], data_in[10:3], ste_level[11]
    .s_tuser  (s_tuser),  // req_type[2:0]
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)   // rd_data, tx_valid, tx_char, tx_break, spi_out, rx_irq,
                          // tx_irq, clear_fifos, timer_start, timer_stop
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- prediction

  function automatic logic [7:0] rx_format(input logic [7:0] d);
    logic [7:0] r;
    r = d;
    if (ctl0_m[CTL0_MSB]) begin
      r = {<<{d}};
      if (ctl0_m[CTL0_7BIT]) begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] tx_format(input logic [7:0] t);
    logic [7:0] r;
    r = t;
    if (ctl0_m[CTL0_7BIT]) begin
      r[7] = 1'b0;
    end
    if (ctl0_m[CTL0_MSB]) begin
      r = {<<{r}};
      if (ctl0_m[CTL0_7BIT]) begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  function automatic void line_receive(input logic [7:0] c);
    if (unread_m) begin
      stat_m[STAT_OE] = 1'b1;
      stat_m[STAT_RXERR] = 1'b1;
      if (ctl1_m[CTL1_RXEIE]) begin
        rx_irq_m = 1'b1;
      end
    end else begin
      rxbuf_m = rx_format(c);
      unread_m = 1'b1;
      if (!ctl1_m[CTL1_DORM]) begin
        rx_irq_m = 1'b1;
      end
    end
  endfunction

  function automatic void start_send(inout line_result_t r);
    r.tx_valid = 1'b1;
    if (ctl1_m[CTL1_TXBRK]) begin
      r.tx_break = 1'b1;
      ctl1_m[CTL1_TXBRK] = 1'b0;
    end else begin
      r.tx_char = tx_format(txbuf_m);
    end
    if (stat_m[STAT_LISTEN]) begin
      line_receive(txbuf_m);
    end
    r.timer_start = 1'b1;
    if (!txrdy_m) begin
      tx_irq_m = 1'b1;
    end
    busy_m = 1'b1;
    txrdy_m = 1'b1;
  endfunction

  function automatic line_result_t bus_event_result(input logic [2:0] kind,
                                                    input logic [2:0] addr,
                                                    input logic [7:0] din,
                                                    input logic       ste);
    line_result_t r;
    spi_mode_t    mode;
    logic         take;
    r = '0;
    case (kind)
      REQ_READ: begin
        case (addr)
          ADDR_CTL0: r.rd_data = ctl0_m;
          ADDR_CTL1: r.rd_data = ctl1_m;
          ADDR_BR0:  r.rd_data = baud_m[7:0];
          ADDR_BR1:  r.rd_data = baud_m[15:8];
          ADDR_MCTL: r.rd_data = mctl_m;
          ADDR_STAT: begin
            stat_m[STAT_BUSY] = busy_m;
            r.rd_data = stat_m;
          end
          ADDR_RXBUF: begin
            rx_irq_m = 1'b0;
            stat_m = stat_m & ~STAT_RX_BITS;
            unread_m = 1'b0;
            r.rd_data = rxbuf_m;
          end
          default: r.rd_data = txbuf_m;
        endcase
      end
      REQ_WRITE: begin
        case (addr)
          ADDR_CTL0: begin
            ctl0_m = din;
            r.timer_stop = !ctl1_m[CTL1_SWRST];
          end
          ADDR_CTL1: begin
            if (din[CTL1_SWRST] != ctl1_m[CTL1_SWRST]) begin
              r.timer_stop = 1'b1;
              if (din[CTL1_SWRST]) begin
                r.clear_fifos = 1'b1;
                rx_irq_m = 1'b0;
                tx_irq_m = 1'b1;
                busy_m = 1'b0;
                txrdy_m = 1'b1;
                unread_m = 1'b0;
                stat_m = stat_m & ~STAT_RX_BITS;
              end
            end
            ctl1_m = din;
          end
          ADDR_BR0: begin
            baud_m[7:0] = din;
            r.timer_stop = !ctl1_m[CTL1_SWRST];
          end
          ADDR_BR1: begin
            baud_m[15:8] = din;
            r.timer_stop = !ctl1_m[CTL1_SWRST];
          end
          ADDR_MCTL: begin
            mctl_m = din;
            r.timer_stop = !ctl1_m[CTL1_SWRST] && !ctl0_m[CTL0_SYNC];
          end
          ADDR_STAT: stat_m = din;
          ADDR_RXBUF: ;
          default: begin
            txbuf_m = din;
            start_send(r);
          end
        endcase
      end
      REQ_RX_CHAR: begin
        if (!ctl1_m[CTL1_SWRST] && !stat_m[STAT_LISTEN]) begin
          line_receive(din);
        end
      end
      REQ_RX_BREAK: begin
        stat_m[STAT_BRK] = 1'b1;
        if (ctl1_m[CTL1_BRKIE]) begin
          rx_irq_m = 1'b1;
        end
        line_receive(8'h00);
      end
      REQ_TICK: begin
        if (txrdy_m) begin
          busy_m = 1'b0;
        end else begin
          start_send(r);
        end
      end
      REQ_SPI: begin
        mode = spi_mode_t'(ctl0_m[2:1]);  // spi mode field
        take = !ctl1_m[CTL1_SWRST] && !stat_m[STAT_LISTEN] && ctl0_m[CTL0_SYNC] &&
               mode != SPI_MODE_I2C && !(mode == SPI_MODE_STE_HI && !ste) &&
               !(mode == SPI_MODE_STE_LO && ste);
        if (take) begin
          if (unread_m) begin
            stat_m[STAT_OE] = 1'b1;
          end else begin
            rxbuf_m = rx_format(din);
            unread_m = 1'b1;
            rx_irq_m = 1'b1;
          end
          tx_irq_m = 1'b1;
          txrdy_m = 1'b1;
          r.spi_out = tx_format(txbuf_m);
        end
      end
      default: ;
    endcase
    r.rx_irq = rx_irq_m;
    r.tx_irq = tx_irq_m;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_error(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 40) begin
      $display("%0t ERROR %s", $time, msg);
    end
  endtask

  task automatic report_field(input string name, input logic [7:0] got, input logic [7:0] want);
    report_error($sformatf("result %0d %s: got %h, want %h", checked_cnt, name, got, want));
  endtask

  task automatic report_flag(input string name, input logic got, input logic want);
    report_error($sformatf("result %0d %s: got %b, want %b", checked_cnt, name, got, want));
  endtask

  always @(posedge clk) begin
    line_result_t got;
    line_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_results.size() == 0) begin
        report_error($sformatf("result %h with no item outstanding", m_tdata));
      end else begin
        want = pending_results.pop_front();
        if (got.rd_data !== want.rd_data) report_field("rd_data", got.rd_data, want.rd_data);
        if (got.tx_valid !== want.tx_valid) report_flag("tx_valid", got.tx_valid, want.tx_valid);
        if (got.tx_char !== want.tx_char) report_field("tx_char", got.tx_char, want.tx_char);
        if (got.tx_break !== want.tx_break) report_flag("tx_break", got.tx_break, want.tx_break);
        if (got.spi_out !== want.spi_out) report_field("spi_out", got.spi_out, want.spi_out);
        if (got.rx_irq !== want.rx_irq) report_flag("rx_irq", got.rx_irq, want.rx_irq);
        if (got.tx_irq !== want.tx_irq) report_flag("tx_irq", got.tx_irq, want.tx_irq);
        if (got.clear_fifos !== want.clear_fifos)
          report_flag("clear_fifos", got.clear_fifos, want.clear_fifos);
        if (got.timer_start !== want.timer_start)
          report_flag("timer_start", got.timer_start, want.timer_start);
        if (got.timer_stop !== want.timer_stop)
          report_flag("timer_stop", got.timer_stop, want.timer_stop);
        if (got.spare !== want.spare) report_flag("pad bit", got.spare, want.spare);
        checked_cnt++;
      end
    end
  end

  // sink side: random stall bursts; new bursts start only while idle_on is set
  always @(posedge clk) begin
    if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      sink_gap <= $urandom_range(0, 7);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic put_item(input logic [2:0] kind, input logic [2:0] addr,
                          input logic [7:0] din, input logic ste);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {4'b0000, ste, din, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(bus_event_result(kind, addr, din, ste));
    kind_cnt[kind]++;
    item_cnt++;
  endtask

  // hold the sender until every outstanding result has been taken or the guard runs out
  task automatic wait_drained();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    do begin
      @(posedge clk);
      guard++;
    end while (pending_results.size() != 0 && guard < 20000);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_after_reset();
    put_item(REQ_READ, ADDR_CTL1, 8'h00, 1'b0);
    put_item(REQ_RX_CHAR, ADDR_CTL0, 8'ha5, 1'b0);   // dropped while in soft reset
    put_item(REQ_SPI, ADDR_CTL0, 8'hff, 1'b1);
    put_item(REQ_NONE, ADDR_TXBUF, 8'hff, 1'b1);
    put_item(REQ_SPARE, ADDR_TXBUF, 8'h00, 1'b0);
  endtask

  task automatic test_uart_path();
    put_item(REQ_WRITE, ADDR_CTL1, 8'h38, 1'b0);     // dormant, break and error irqs
    put_item(REQ_WRITE, ADDR_CTL0, 8'h30, 1'b0);     // 7-bit, msb first
    put_item(REQ_WRITE, ADDR_TXBUF, 8'hff, 1'b0);
    put_item(REQ_TICK, ADDR_CTL0, 8'h00, 1'b0);
    put_item(REQ_RX_CHAR, ADDR_CTL0, 8'h81, 1'b0);
    put_item(REQ_RX_CHAR, ADDR_CTL0, 8'h7e, 1'b0);   // overrun
    put_item(REQ_RX_BREAK, ADDR_CTL0, 8'h00, 1'b0);
    put_item(REQ_READ, ADDR_STAT, 8'h00, 1'b0);
    put_item(REQ_READ, ADDR_RXBUF, 8'h00, 1'b0);
    put_item(REQ_WRITE, ADDR_CTL1, 8'h02, 1'b0);     // break on next send
    put_item(REQ_WRITE, ADDR_TXBUF, 8'h55, 1'b0);
    put_item(REQ_WRITE, ADDR_STAT, 8'h80, 1'b0);     // listen
    put_item(REQ_WRITE, ADDR_TXBUF, 8'ha3, 1'b0);
    put_item(REQ_WRITE, ADDR_RXBUF, 8'h12, 1'b0);
    put_item(REQ_READ, ADDR_RXBUF, 8'h00, 1'b0);
    put_item(REQ_WRITE, ADDR_BR0, 8'hff, 1'b0);
    put_item(REQ_WRITE, ADDR_BR1, 8'h80, 1'b0);
    put_item(REQ_WRITE, ADDR_MCTL, 8'hff, 1'b0);
  endtask

  task automatic test_spi_path();
    put_item(REQ_WRITE, ADDR_CTL1, 8'h01, 1'b0);     // back into soft reset
    put_item(REQ_WRITE, ADDR_STAT, 8'h00, 1'b0);
    put_item(REQ_WRITE, ADDR_CTL0, {5'b00000, SPI_MODE_STE_HI, 1'b1}, 1'b0);
    put_item(REQ_WRITE, ADDR_CTL1, 8'h00, 1'b0);
    put_item(REQ_SPI, ADDR_CTL0, 8'hc1, 1'b1);
    put_item(REQ_SPI, ADDR_CTL0, 8'h3c, 1'b0);
    put_item(REQ_WRITE, ADDR_CTL0, {5'b00000, SPI_MODE_STE_LO, 1'b1}, 1'b0);
    put_item(REQ_SPI, ADDR_CTL0, 8'h00, 1'b0);       // overrun
    put_item(REQ_WRITE, ADDR_CTL0, {5'b00000, SPI_MODE_I2C, 1'b1}, 1'b0);
    put_item(REQ_SPI, ADDR_CTL0, 8'h5a, 1'b1);
  endtask

  // re-enter soft reset, then leave it, with fresh random control settings
  task automatic restart_session();
    logic [7:0] ctl1_val;
    put_item(REQ_WRITE, ADDR_CTL1, 8'h01 | 8'($urandom_range(0, 255)), 1'b0);
    put_item(REQ_WRITE, ADDR_CTL0, 8'($urandom_range(0, 255)), 1'b0);
    put_item(REQ_WRITE, ADDR_STAT, $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 127)),
             1'b0);
    ctl1_val = 8'($urandom_range(0, 255));
    ctl1_val[CTL1_SWRST] = 1'b0;
    put_item(REQ_WRITE, ADDR_CTL1, ctl1_val, 1'b0);
  endtask

  task automatic random_item();
    int unsigned sel;
    logic [2:0]  kind;
    logic [2:0]  addr;
    logic [7:0]  din;
    sel  = $urandom_range(0, 99);
    addr = 3'($urandom_range(0, 7));
    din  = 8'($urandom_range(0, 255));
    if (sel < 28) begin
      kind = REQ_READ;
      if ($urandom_range(0, 1) == 1) begin
        addr = $urandom_range(0, 1) ? ADDR_RXBUF : ADDR_STAT;
      end
    end else if (sel < 55) begin
      kind = REQ_WRITE;
      if ($urandom_range(0, 2) == 0) begin
        addr = ADDR_TXBUF;
      end
      if (addr == ADDR_CTL1 && $urandom_range(0, 9) != 0) begin
        din[CTL1_SWRST] = 1'b0;
      end
      if (addr == ADDR_STAT && $urandom_range(0, 4) != 0) begin
        din[STAT_LISTEN] = 1'b0;
      end
    end else if (sel < 70) begin
      kind = REQ_RX_CHAR;
    end else if (sel < 75) begin
      kind = REQ_RX_BREAK;
    end else if (sel < 83) begin
      kind = REQ_TICK;
    end else if (sel < 98) begin
      kind = REQ_SPI;
    end else begin
      kind = $urandom_range(0, 1) ? REQ_NONE : REQ_SPARE;
    end
    put_item(kind, addr, din, 1'($urandom_range(0, 1)));
  endtask

  task automatic test_random_traffic(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        restart_session();
      end
      random_item();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_after_reset();
    test_uart_path();
    test_spi_path();

    test_random_traffic(520);
    wait_drained();
    idle_on <= 1'b0;
    test_random_traffic(280);
    idle_on <= 1'b1;
    test_random_traffic(420);
    wait_drained();
    idle_on <= 1'b0;
    test_random_traffic(180);

    wait_drained();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_error($sformatf("%0d results never arrived", pending_results.size()));
    end

    $display("Sent %0d items: %0d reads, %0d writes, %0d rx chars, %0d breaks, %0d ticks,",
             item_cnt, kind_cnt[REQ_READ], kind_cnt[REQ_WRITE], kind_cnt[REQ_RX_CHAR],
             kind_cnt[REQ_RX_BREAK], kind_cnt[REQ_TICK]);
    $display("%0d spi transfers, %0d unused codes; %0d results checked, %0d mismatches",
             kind_cnt[REQ_SPI], kind_cnt[REQ_NONE] + kind_cnt[REQ_SPARE], checked_cnt,
             mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
